// ===== sv/fpp_pkg.sv =====
// Shared types and constants of the fisheye point projection pipeline.
// Used by fpp_isqrt, fpp_cordic and fisheye_point_projection; depends on nothing.
package fpp_pkg;

  localparam int SQRT_STEPS   = 32;
  localparam int NORM_STEPS   = 6;
  localparam int DIV_BITS     = 21;
  localparam int CORDIC_STEPS = 30;
  localparam int CD_STAGES    = 1 + NORM_STEPS + CORDIC_STEPS;

  typedef logic [2:0] reg_idx_t;
  localparam reg_idx_t REG_FOCAL_X  = 3'd0;
  localparam reg_idx_t REG_FOCAL_Y  = 3'd1;
  localparam reg_idx_t REG_CENTER_X = 3'd2;
  localparam reg_idx_t REG_CENTER_Y = 3'd3;
  localparam reg_idx_t REG_DIST_K1  = 3'd4;
  localparam reg_idx_t REG_DIST_K2  = 3'd5;
  localparam reg_idx_t REG_DIST_K3  = 3'd6;
  localparam reg_idx_t REG_DIST_K4  = 3'd7;

  localparam logic [23:0] RST_FOCAL_X  = 24'd4137448;
  localparam logic [23:0] RST_FOCAL_Y  = 24'd4134889;
  localparam logic [23:0] RST_CENTER_X = 24'd4127738;
  localparam logic [23:0] RST_CENTER_Y = 24'd2365321;
  localparam logic [23:0] RST_DIST_K1  = 24'hFEEF15;
  localparam logic [23:0] RST_DIST_K2  = 24'd946;
  localparam logic [23:0] RST_DIST_K3  = 24'hFFE149;
  localparam logic [23:0] RST_DIST_K4  = 24'd2007;

  localparam logic [30:0] ONE_MM = 31'd256;

  typedef struct packed {
    logic        sx;
    logic        sy;
    logic [31:0] ax;
    logic [31:0] ay;
    logic [30:0] z;
  } pt_t;

  typedef struct packed {
    logic [63:0] n;
    logic [63:0] res;
    pt_t         pt;
  } sq_t;

  typedef struct packed {
    logic [31:0] r;
    pt_t         pt;
  } rad_t;

  typedef struct packed {
    logic signed [32:0] ang;
    logic               rz;
    logic               sx;
    logic               sy;
    logic [20:0]        qx;
    logic [20:0]        qy;
  } ang_t;

  function automatic logic signed [32:0] atan_step(input int i);
    logic signed [32:0] res;
    case (i)
      0:  res = 33'sh03243F6A8;
      1:  res = 33'sh01DAC6705;
      2:  res = 33'sh00FADBAFC;
      3:  res = 33'sh007F56EA6;
      4:  res = 33'sh003FEAB76;
      5:  res = 33'sh001FFD55B;
      6:  res = 33'sh000FFFAAA;
      7:  res = 33'sh0007FFF55;
      8:  res = 33'sh0003FFFEA;
      9:  res = 33'sh0001FFFFD;
      10: res = 33'sh0000FFFFF;
      default: res = 33'((64'sd1 <<< (30 - i)) - 64'sd1);
    endcase
    return res;
  endfunction

endpackage

// ===== sv/fisheye_point_projection.sv =====
// Top level of the fisheye point projection pipeline and its register file.
// Depends on fpp_pkg, fpp_isqrt and fpp_cordic.
//
// A camera-frame point enters on the in_ channel (valid/ready) and its source
// pixel leaves on the out_ channel: column, row and an inside-image flag.
// Focal lengths, principal point and the four distortion coefficients sit in
// an APB register file at byte addresses 0, 4, ... 28; change them only while
// no request is in flight.
// Every request gives exactly one result. One request is taken per cycle
// while the output is not stalled; the rate is set by the single fully
// pipelined datapath: 3 input stages, a 32-stage square root, a 37-stage
// normalize and CORDIC unit with the dividers beside it, and 9 stages of
// polynomial, scaling and clamping.
// While the receiver holds out_ready low with a result waiting, the whole
// pipeline holds and in_ready is low; nothing is dropped or repeated.
// Synchronous reset empties the pipeline and loads the default calibration.
module fisheye_point_projection #(
  parameter int IMG_W = 1920,
  parameter int IMG_H = 1080
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_cam_x,
  input  logic signed [31:0] in_cam_y,
  input  logic signed [31:0] in_cam_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [10:0]        out_src_col,
  output logic [10:0]        out_src_row,
  output logic               out_inside_res,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import fpp_pkg::*;

  localparam logic signed [41:0] U_MAX = 42'(IMG_W - 1) <<< 12;
  localparam logic signed [41:0] V_MAX = 42'(IMG_H - 1) <<< 12;

  typedef struct packed {
    logic [30:0]  th;
    logic [31:0]  t2;
    logic         rz;
    logic         sx;
    logic         sy;
    logic [20:0]  qx;
    logic [20:0]  qy;
  } tail_t;

  logic [23:0] focal_x_r, focal_y_r, center_x_r, center_y_r;
  logic [23:0] dist_k1_r, dist_k2_r, dist_k3_r, dist_k4_r;
  logic        adv;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      focal_x_r  <= RST_FOCAL_X;
      focal_y_r  <= RST_FOCAL_Y;
      center_x_r <= RST_CENTER_X;
      center_y_r <= RST_CENTER_Y;
      dist_k1_r  <= RST_DIST_K1;
      dist_k2_r  <= RST_DIST_K2;
      dist_k3_r  <= RST_DIST_K3;
      dist_k4_r  <= RST_DIST_K4;
    end else if (cfg_wr) begin
      unique case (reg_idx_t'(paddr[4:2]))
        REG_FOCAL_X:  focal_x_r  <= pwdata[23:0];
        REG_FOCAL_Y:  focal_y_r  <= pwdata[23:0];
        REG_CENTER_X: center_x_r <= pwdata[23:0];
        REG_CENTER_Y: center_y_r <= pwdata[23:0];
        REG_DIST_K1:  dist_k1_r  <= pwdata[23:0];
        REG_DIST_K2:  dist_k2_r  <= pwdata[23:0];
        REG_DIST_K3:  dist_k3_r  <= pwdata[23:0];
        REG_DIST_K4:  dist_k4_r  <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_t'(paddr[4:2]))
      REG_FOCAL_X:  prdata = {8'd0, focal_x_r};
      REG_FOCAL_Y:  prdata = {8'd0, focal_y_r};
      REG_CENTER_X: prdata = {8'd0, center_x_r};
      REG_CENTER_Y: prdata = {8'd0, center_y_r};
      REG_DIST_K1:  prdata = {8'd0, dist_k1_r};
      REG_DIST_K2:  prdata = {8'd0, dist_k2_r};
      REG_DIST_K3:  prdata = {8'd0, dist_k3_r};
      REG_DIST_K4:  prdata = {8'd0, dist_k4_r};
      default:      prdata = '0;
    endcase
  end

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  logic        v0_r, v1_r, v2_r;
  pt_t         pt0_r, pt1_r, pt_nxt;
  logic [63:0] sqx1_r, sqy1_r;
  sq_t         sq2_r, sq_nxt;

  always_comb begin
    pt_nxt.sx = in_cam_x[31];
    pt_nxt.sy = in_cam_y[31];
    pt_nxt.ax = in_cam_x[31] ? (~in_cam_x + 32'd1) : in_cam_x;
    pt_nxt.ay = in_cam_y[31] ? (~in_cam_y + 32'd1) : in_cam_y;
    pt_nxt.z  = (in_cam_z <= 32'sd0) ? ONE_MM : in_cam_z[30:0];
    sq_nxt.n   = sqx1_r + sqy1_r;
    sq_nxt.res = '0;
    sq_nxt.pt  = pt1_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pt0_r  <= pt_nxt;
      pt1_r  <= pt0_r;
      sqx1_r <= 64'(pt0_r.ax) * 64'(pt0_r.ax);
      sqy1_r <= 64'(pt0_r.ay) * 64'(pt0_r.ay);
      sq2_r  <= sq_nxt;
    end
  end

  logic sq_v, cd_v;
  rad_t sq_o;
  ang_t cd_o;

  fpp_isqrt u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (v2_r),
    .in_data   (sq2_r),
    .out_valid (sq_v),
    .out_data  (sq_o)
  );

  fpp_cordic u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (sq_v),
    .in_data   (sq_o),
    .out_valid (cd_v),
    .out_data  (cd_o)
  );

  logic               vt_r, vh1_r, vh2_r, vh3_r, vh4_r, vd_r, vm1_r, vm2_r;
  tail_t              tt_r, th1_r, th2_r, th3_r, th4_r, td_r;
  tail_t              tt_nxt;
  logic [30:0]        th_clip;
  logic signed [31:0] a1_r, a2_r, a3_r, q_r;
  logic signed [56:0] p1;
  logic signed [64:0] p2, p3, p4;
  logic signed [63:0] pd;
  logic signed [33:0] thd_r;
  logic signed [21:0] cx, cy;
  logic signed [55:0] pmx, pmy;
  logic signed [35:0] px_r, py_r;
  logic               rz_m1_r;
  logic signed [60:0] pux, puy;
  logic signed [41:0] u_r, v_r;
  logic signed [41:0] u_nxt, v_nxt;
  logic [61:0]        th_sq;

  always_comb begin
    th_clip   = cd_o.ang[32] ? 31'd0 : cd_o.ang[30:0];
    th_sq     = 62'(th_clip) * 62'(th_clip);
    tt_nxt.th = th_clip;
    tt_nxt.t2 = th_sq[61:30];
    tt_nxt.rz = cd_o.rz;
    tt_nxt.sx = cd_o.sx;
    tt_nxt.sy = cd_o.sy;
    tt_nxt.qx = cd_o.qx;
    tt_nxt.qy = cd_o.qy;

    p1 = 57'($signed(dist_k4_r)) * 57'($signed({1'b0, tt_r.t2}));
    p2 = 65'(a1_r) * 65'($signed({1'b0, th1_r.t2}));
    p3 = 65'(a2_r) * 65'($signed({1'b0, th2_r.t2}));
    p4 = 65'(a3_r) * 65'($signed({1'b0, th3_r.t2}));
    pd = 64'(q_r) * 64'($signed({1'b0, th4_r.th}));

    cx  = td_r.sx ? -$signed({1'b0, td_r.qx}) : $signed({1'b0, td_r.qx});
    cy  = td_r.sy ? -$signed({1'b0, td_r.qy}) : $signed({1'b0, td_r.qy});
    pmx = 56'(cx) * 56'(thd_r);
    pmy = 56'(cy) * 56'(thd_r);

    pux = 61'($signed({1'b0, focal_x_r})) * 61'(px_r);
    puy = 61'($signed({1'b0, focal_y_r})) * 61'(py_r);
    if (rz_m1_r) begin
      u_nxt = 42'($signed({1'b0, center_x_r}));
      v_nxt = 42'($signed({1'b0, center_y_r}));
    end else begin
      u_nxt = 42'(pux >>> 20) + 42'($signed({1'b0, center_x_r}));
      v_nxt = 42'(puy >>> 20) + 42'($signed({1'b0, center_y_r}));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tt_r    <= tt_nxt;
      th1_r   <= tt_r;
      a1_r    <= 32'($signed(dist_k3_r)) + 32'(p1 >>> 30);
      th2_r   <= th1_r;
      a2_r    <= 32'($signed(dist_k2_r)) + 32'(p2 >>> 30);
      th3_r   <= th2_r;
      a3_r    <= 32'($signed(dist_k1_r)) + 32'(p3 >>> 30);
      th4_r   <= th3_r;
      q_r     <= 32'sd1048576 + 32'(p4 >>> 30);
      td_r    <= th4_r;
      thd_r   <= 34'(pd >>> 30);
      rz_m1_r <= td_r.rz;
      px_r    <= 36'(pmx >>> 20);
      py_r    <= 36'(pmy >>> 20);
      u_r     <= u_nxt;
      v_r     <= v_nxt;
    end
  end

  logic        out_valid_r;
  logic [10:0] col_r, row_r, col_nxt, row_nxt;
  logic        inside_r, inside_nxt;

  always_comb begin
    inside_nxt = 1'b1;
    if (u_r < 0) begin
      col_nxt    = '0;
      inside_nxt = 1'b0;
    end else if (u_r > U_MAX) begin
      col_nxt    = 11'(IMG_W - 1);
      inside_nxt = 1'b0;
    end else begin
      col_nxt = u_r[22:12];
    end
    if (v_r < 0) begin
      row_nxt    = '0;
      inside_nxt = 1'b0;
    end else if (v_r > V_MAX) begin
      row_nxt    = 11'(IMG_H - 1);
      inside_nxt = 1'b0;
    end else begin
      row_nxt = v_r[22:12];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      inside_r <= inside_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r        <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      vt_r        <= 1'b0;
      vh1_r       <= 1'b0;
      vh2_r       <= 1'b0;
      vh3_r       <= 1'b0;
      vh4_r       <= 1'b0;
      vd_r        <= 1'b0;
      vm1_r       <= 1'b0;
      vm2_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v0_r        <= in_valid;
      v1_r        <= v0_r;
      v2_r        <= v1_r;
      vt_r        <= cd_v;
      vh1_r       <= vt_r;
      vh2_r       <= vh1_r;
      vh3_r       <= vh2_r;
      vh4_r       <= vh3_r;
      vd_r        <= vh4_r;
      vm1_r       <= vd_r;
      vm2_r       <= vm1_r;
      out_valid_r <= vm2_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_src_col    = col_r;
  assign out_src_row    = row_r;
  assign out_inside_res = inside_r;

endmodule

// ===== sv/fpp_isqrt.sv =====
// Pipelined integer square root, one result bit per stage.
// Depends on fpp_pkg for the stage and result types.
module fpp_isqrt (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         adv,
  input  logic         in_valid,
  input  fpp_pkg::sq_t in_data,
  output logic         out_valid,
  output fpp_pkg::rad_t out_data
);
  import fpp_pkg::*;

  logic [SQRT_STEPS-1:0] vld_r;
  sq_t                   st_r [SQRT_STEPS];

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_step
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * j);
    sq_t         prev;
    sq_t         st_nxt;
    logic [63:0] trial;

    if (j == 0) begin : g_first
      assign prev = in_data;
    end else begin : g_next
      assign prev = st_r[j-1];
    end

    always_comb begin
      st_nxt = prev;
      trial  = prev.res + BIT;
      if (prev.n >= trial) begin
        st_nxt.n   = prev.n - trial;
        st_nxt.res = (prev.res >> 1) + BIT;
      end else begin
        st_nxt.res = prev.res >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st_r[j] <= st_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[SQRT_STEPS-2:0], in_valid};
    end
  end

  assign out_valid   = vld_r[SQRT_STEPS-1];
  assign out_data.r  = st_r[SQRT_STEPS-1].res[31:0];
  assign out_data.pt = st_r[SQRT_STEPS-1].pt;

endmodule

// ===== sv/fpp_cordic.sv =====
// Pipelined angle unit: operand normalization, CORDIC vectoring for atan2(r, z)
// and the two restoring dividers for x/r and y/r. Depends on fpp_pkg.
module fpp_cordic (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          adv,
  input  logic          in_valid,
  input  fpp_pkg::rad_t in_data,
  output logic          out_valid,
  output fpp_pkg::ang_t out_data
);
  import fpp_pkg::*;

  typedef struct packed {
    logic [40:0]        m;
    logic signed [44:0] a;
    logic signed [44:0] b;
    logic signed [32:0] ang;
    logic [31:0]        r;
    logic [52:0]        nx;
    logic [52:0]        ny;
    logic [20:0]        qx;
    logic [20:0]        qy;
    logic               sx;
    logic               sy;
    logic               rz;
  } cd_t;

  logic [CD_STAGES-1:0] vld_r;
  cd_t                  st_r [CD_STAGES];

  for (genvar s = 0; s < CD_STAGES; s++) begin : g_stage
    cd_t st_nxt;

    if (s == 0) begin : g_init
      always_comb begin
        st_nxt     = '0;
        st_nxt.m   = (41'(in_data.r) > 41'(in_data.pt.z)) ? 41'(in_data.r)
                                                          : 41'(in_data.pt.z);
        st_nxt.a   = 45'(in_data.pt.z);
        st_nxt.b   = 45'(in_data.r);
        st_nxt.r   = in_data.r;
        st_nxt.nx  = 53'({in_data.pt.ax, 20'd0});
        st_nxt.ny  = 53'({in_data.pt.ay, 20'd0});
        st_nxt.sx  = in_data.pt.sx;
        st_nxt.sy  = in_data.pt.sy;
        st_nxt.rz  = (in_data.r == 32'd0);
      end
    end else begin : g_work
      localparam int K  = 64 >> s;
      localparam int Q  = DIV_BITS - s;
      localparam int QI = (Q < 0) ? 0 : Q;
      localparam int I  = s - 1 - NORM_STEPS;
      localparam int II = (I < 0) ? 0 : I;
      localparam logic signed [32:0] STEP = atan_step(II);
      cd_t         p;
      logic [52:0] rk;
      assign p = st_r[s-1];

      always_comb begin
        st_nxt = p;
        rk     = 53'(p.r) << QI;
        if (s <= NORM_STEPS) begin
          if (p.m < (41'd1 << (41 - K))) begin
            st_nxt.m = p.m << K;
            st_nxt.a = p.a <<< K;
            st_nxt.b = p.b <<< K;
          end
        end
        if (Q >= 0) begin
          if (p.nx >= rk) begin
            st_nxt.nx     = p.nx - rk;
            st_nxt.qx[QI] = 1'b1;
          end
          if (p.ny >= rk) begin
            st_nxt.ny     = p.ny - rk;
            st_nxt.qy[QI] = 1'b1;
          end
        end
        if (I >= 0) begin
          if (p.b > 0) begin
            st_nxt.a   = p.a + (p.b >>> II);
            st_nxt.b   = p.b - (p.a >>> II);
            st_nxt.ang = p.ang + STEP;
          end else begin
            st_nxt.a   = p.a - (p.b >>> II);
            st_nxt.b   = p.b + (p.a >>> II);
            st_nxt.ang = p.ang - STEP;
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st_r[s] <= st_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[CD_STAGES-2:0], in_valid};
    end
  end

  assign out_valid    = vld_r[CD_STAGES-1];
  assign out_data.ang = st_r[CD_STAGES-1].ang;
  assign out_data.rz  = st_r[CD_STAGES-1].rz;
  assign out_data.sx  = st_r[CD_STAGES-1].sx;
  assign out_data.sy  = st_r[CD_STAGES-1].sy;
  assign out_data.qx  = st_r[CD_STAGES-1].qx;
  assign out_data.qy  = st_r[CD_STAGES-1].qy;

endmodule

// ===== tb/sv/fisheye_point_projection_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for fisheye_point_projection: drives camera points and APB writes,
// predicts every pixel in fixed point and compares it with the result channel.
// Depends on fpp_pkg and the fisheye_point_projection RTL only.
module fisheye_point_projection_tb;
  import fpp_pkg::*;

  localparam int IMG_W = 1920;
  localparam int IMG_H = 1080;
  localparam int HOLD_CYCLES = 200;
  localparam longint ANGLE_TAB [0:10] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
    64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF
  };

  typedef struct packed {
    logic [10:0] col;
    logic [10:0] row;
    logic        in_img;
  } pixel_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic signed [31:0] in_cam_x;
  logic signed [31:0] in_cam_y;
  logic signed [31:0] in_cam_z;
  logic               out_valid;
  logic               out_ready;
  logic [10:0]        out_src_col;
  logic [10:0]        out_src_row;
  logic               out_inside_res;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [4:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  logic [23:0]        focal_x, focal_y, center_x, center_y;
  logic signed [23:0] k1, k2, k3, k4;

  pixel_t pixel_q [$];
  int     error_count = 0;
  int     hold_req = 0;
  bit     idle_enable = 1;

  fisheye_point_projection #(.IMG_W(IMG_W), .IMG_H(IMG_H)) i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_cam_x(in_cam_x), .in_cam_y(in_cam_y), .in_cam_z(in_cam_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_src_col(out_src_col), .out_src_row(out_src_row), .out_inside_res(out_inside_res),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic longint view_angle(input longint r, input longint z);
    longint m, a, b, ang, step, na, nb;
    m = (r > z) ? r : z;
    a = z;
    b = r;
    ang = 0;
    while (m < (64'sd1 <<< 40)) begin
      m = m <<< 1;
      a = a <<< 1;
      b = b <<< 1;
    end
    for (int i = 0; i < 30; i++) begin
      step = (i < 11) ? ANGLE_TAB[i] : ((64'sd1 <<< (30 - i)) - 1);
      if (b > 0) begin
        na = a + (b >>> i);
        nb = b - (a >>> i);
        ang = ang + step;
      end else begin
        na = a - (b >>> i);
        nb = b + (a >>> i);
        ang = ang - step;
      end
      a = na;
      b = nb;
    end
    return (ang < 0) ? 0 : ang;
  endfunction

  function automatic longint axis_ratio(input longint c, input longint unsigned r);
    longint unsigned mag;
    longint q;
    mag = (c < 0) ? longint'(-c) : longint'(c);
    q = longint'((mag << 20) / r);
    return (c < 0) ? -q : q;
  endfunction

  function automatic logic [10:0] clamp_pixel(input longint p, input longint lim,
                                              inout logic in_img);
    if (p < 0) begin
      in_img = 1'b0;
      return 11'd0;
    end
    if (p > (lim <<< 12)) begin
      in_img = 1'b0;
      return lim[10:0];
    end
    return 11'(p >>> 12);
  endfunction

  function automatic pixel_t project_point(input logic signed [31:0] px,
                                           input logic signed [31:0] py,
                                           input logic signed [31:0] pz);
    longint x, y, z, u, v, th, t2, a, q, thd, cx, cy;
    longint unsigned ax, ay, r;
    logic in_img;
    pixel_t res;
    x = px;
    y = py;
    z = pz;
    in_img = 1'b1;
    if (z <= 0) z = ONE_MM;
    ax = (x < 0) ? longint'(-x) : longint'(x);
    ay = (y < 0) ? longint'(-y) : longint'(y);
    r = int_sqrt(ax * ax + ay * ay);
    if (r == 0) begin
      u = center_x;
      v = center_y;
    end else begin
      th = view_angle(longint'(r), z);
      t2 = longint'((longint'(unsigned'(th)) * longint'(unsigned'(th))) >> 30);
      a = k4;
      a = longint'(k3) + ((a * t2) >>> 30);
      a = longint'(k2) + ((a * t2) >>> 30);
      a = longint'(k1) + ((a * t2) >>> 30);
      q = (64'sd1 <<< 20) + ((a * t2) >>> 30);
      thd = (q * th) >>> 30;
      cx = axis_ratio(x, r);
      cy = axis_ratio(y, r);
      u = ((longint'(focal_x) * ((cx * thd) >>> 20)) >>> 20) + longint'(center_x);
      v = ((longint'(focal_y) * ((cy * thd) >>> 20)) >>> 20) + longint'(center_y);
    end
    res.col = clamp_pixel(u, IMG_W - 1, in_img);
    res.row = clamp_pixel(v, IMG_H - 1, in_img);
    res.in_img = in_img;
    return res;
  endfunction

  // Every accepted request is predicted against the calibration held at that moment.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      pixel_q = {pixel_q, project_point(in_cam_x, in_cam_y, in_cam_z)};
  end

  always @(posedge clk) begin
    pixel_t exp_px;
    if (rst_n && out_valid && out_ready) begin
      if (pixel_q.size() == 0) begin
        $display("%0t: unexpected result col=%0d row=%0d inside=%0d", $time,
                 out_src_col, out_src_row, out_inside_res);
        error_count++;
      end else begin
        exp_px = pixel_q.pop_front();
        if (out_src_col !== exp_px.col) begin
          $display("%0t: src_col expected %0d actual %0d", $time, exp_px.col, out_src_col);
          error_count++;
        end
        if (out_src_row !== exp_px.row) begin
          $display("%0t: src_row expected %0d actual %0d", $time, exp_px.row, out_src_row);
          error_count++;
        end
        if (out_inside_res !== exp_px.in_img) begin
          $display("%0t: inside_res expected %0d actual %0d", $time, exp_px.in_img,
                   out_inside_res);
          error_count++;
        end
      end
    end
  end

  // The receiver stalls in gaps of random length; a long hold-off overrides them.
  always @(negedge clk) begin
    static int gap = 0;
    static int hold_left = 0;
    static int hold_seen = 0;
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else if (gap > 0) begin
      gap = gap - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (idle_enable && $urandom_range(0, 3) == 0)
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    end
  end

  task automatic send_point(input logic signed [31:0] x, input logic signed [31:0] y,
                            input logic signed [31:0] z);
    int gap;
    @(negedge clk);
    in_valid <= 1'b1;
    in_cam_x <= x;
    in_cam_y <= y;
    in_cam_z <= z;
    do @(posedge clk); while (!in_ready);
    gap = 0;
    if (idle_enable && $urandom_range(0, 2) == 0)
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pixel_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [23:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {8'h00, value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_FOCAL_X:  focal_x = value;
      REG_FOCAL_Y:  focal_y = value;
      REG_CENTER_X: center_x = value;
      REG_CENTER_Y: center_y = value;
      REG_DIST_K1:  k1 = value;
      REG_DIST_K2:  k2 = value;
      REG_DIST_K3:  k3 = value;
      default:      k4 = value;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic write_calibration(input logic [23:0] fx, input logic [23:0] fy,
                                   input logic [23:0] ux, input logic [23:0] uy,
                                   input logic [23:0] d1, input logic [23:0] d2,
                                   input logic [23:0] d3, input logic [23:0] d4);
    wait_idle();
    write_reg(REG_FOCAL_X, fx);
    write_reg(REG_FOCAL_Y, fy);
    write_reg(REG_CENTER_X, ux);
    write_reg(REG_CENTER_Y, uy);
    write_reg(REG_DIST_K1, d1);
    write_reg(REG_DIST_K2, d2);
    write_reg(REG_DIST_K3, d3);
    write_reg(REG_DIST_K4, d4);
  endtask

  task automatic send_random_point();
    logic signed [31:0] x, y, z;
    case ($urandom_range(0, 9))
      0, 1: begin
        x = $urandom();
        y = $urandom();
        z = $urandom();
      end
      2: begin
        x = $signed($urandom_range(0, 8000)) - 4000;
        y = $signed($urandom_range(0, 8000)) - 4000;
        z = -$signed($urandom_range(0, 100000));
      end
      3: begin
        x = 0;
        y = 0;
        z = $urandom();
      end
      default: begin
        x = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
        y = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
        z = $urandom_range(1, 1 << 20);
      end
    endcase
    send_point(x, y, z);
  endtask

  task automatic test_extremes();
    send_point(0, 0, 256000);
    send_point(0, 0, 0);
    send_point(0, 0, 32'sh80000000);
    send_point(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
    send_point(32'sh80000000, 32'sh80000000, 1);
    send_point(32'sh80000000, 32'sh7FFFFFFF, 0);
    send_point(32'sh7FFFFFFF, 0, -1);
    send_point(0, 32'sh80000000, 32'sh7FFFFFFF);
    send_point(1, 0, 32'sh7FFFFFFF);
    send_point(0, -1, 1);
    send_point(25600, 12800, 256000);
    send_point(-25600, -12800, 256000);
    send_point(256000, 0, 256);
    send_point(-256000, 0, 256);
    send_point(0, 256000, 256);
    send_point(0, -256000, 256);
    send_point(-256000, -256000, -256000);
  endtask

  task automatic test_calibration_sweep();
    write_calibration(24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0);
    repeat (20) send_random_point();
    write_calibration(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                      24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
    repeat (20) send_random_point();
    write_calibration(24'hFFFFFF, 24'hFFFFFF, 24'd0, 24'd0,
                      24'h800000, 24'h800000, 24'h800000, 24'h800000);
    repeat (20) send_random_point();
    write_calibration(24'($urandom()), 24'($urandom()), 24'($urandom()), 24'($urandom()),
                      24'($urandom()), 24'($urandom()), 24'($urandom()), 24'($urandom()));
    repeat (20) send_random_point();
    write_calibration(RST_FOCAL_X, RST_FOCAL_Y, RST_CENTER_X, RST_CENTER_Y,
                      RST_DIST_K1, RST_DIST_K2, RST_DIST_K3, RST_DIST_K4);
  endtask

  task automatic test_random_points();
    idle_enable = 1'b0;
    repeat (60) send_random_point();
    idle_enable = 1'b1;
    repeat (230) send_random_point();
  endtask

  task automatic test_backpressure();
    hold_req++;
    repeat (120) send_random_point();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_cam_x = '0;
    in_cam_y = '0;
    in_cam_z = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    focal_x = RST_FOCAL_X;
    focal_y = RST_FOCAL_Y;
    center_x = RST_CENTER_X;
    center_y = RST_CENTER_Y;
    k1 = RST_DIST_K1;
    k2 = RST_DIST_K2;
    k3 = RST_DIST_K3;
    k4 = RST_DIST_K4;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_extremes();
    test_calibration_sweep();
    test_random_points();
    test_backpressure();
    wait_idle();
    repeat (100) @(negedge clk);
    if (error_count == 0 && pixel_q.size() == 0) begin
      $display("fisheye_point_projection: match");
    end else begin
      $display("fisheye_point_projection: mismatch");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("fisheye_point_projection: mismatch");
    $finish;
  end

endmodule

// ===== files.f =====
sv/fpp_pkg.sv
sv/fpp_isqrt.sv
sv/fpp_cordic.sv
sv/fisheye_point_projection.sv
tb/sv/fisheye_point_projection_tb.sv
